/* sv/dls_pkg.sv */
// Shared types, character codes and defaults for the decimal literal scanner.
package dls_pkg;

	// Default configuration handed down from the top level.
	localparam int SIG_DIGITS_DEF = 19;
	localparam int COUNT_BITS_DEF = 16;

	// Fixed widths of the stream fields.
	localparam int CHAR_W  = 8;
	localparam int SIG_W   = 64;
	localparam int EXP_W   = 18;
	localparam int SFX_W   = 2;
	localparam int ODATA_W = 88;
	localparam int OUSER_W = 4;

	// Scanner states.
	typedef enum logic [3:0] {
		S_START   = 4'd0,
		S_LEADPT  = 4'd1,
		S_FRAC    = 4'd2,
		S_FRAC_US = 4'd3,
		S_EXP     = 4'd4,
		S_EXP_NEG = 4'd5,
		S_EXPD    = 4'd6,
		S_EXP_US  = 4'd7,
		S_SUF     = 4'd8,
		S_INT     = 4'd9,
		S_INT_US  = 4'd10,
		S_POINT   = 4'd11,
		S_ZERO    = 4'd12,
		S_REJ     = 4'd13
	} scan_state_t;

	// Suffix codes.
	localparam logic [SFX_W-1:0] SFX_NONE = 2'd0;
	localparam logic [SFX_W-1:0] SFX_F    = 2'd1;
	localparam logic [SFX_W-1:0] SFX_D    = 2'd2;

	// Character codes.
	localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
	localparam logic [CHAR_W-1:0] CH_POINT  = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_US     = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_E_LO   = 8'h65;
	localparam logic [CHAR_W-1:0] CH_E_UP   = 8'h45;
	localparam logic [CHAR_W-1:0] CH_F_LO   = 8'h66;
	localparam logic [CHAR_W-1:0] CH_F_UP   = 8'h46;
	localparam logic [CHAR_W-1:0] CH_D_LO   = 8'h64;
	localparam logic [CHAR_W-1:0] CH_D_UP   = 8'h44;

	// One finished scan, as handed to the output register.
	typedef struct packed {
		logic                    accepted;
		logic [SIG_W-1:0]        significand;
		logic signed [EXP_W-1:0] decimal_exponent;
		logic [SFX_W-1:0]        suffix_kind;
		logic                    inexact;
	} result_t;

endpackage

/* sv/dls_scan.sv */
// Scanner state machine and digit accumulators for one character per cycle while step is high.
module dls_scan #(
	parameter int SIG_DIGITS = dls_pkg::SIG_DIGITS_DEF,
	parameter int COUNT_BITS = dls_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [dls_pkg::CHAR_W-1:0]    char_code,
	input  logic                          is_last,
	output dls_pkg::result_t              result
);

	localparam int HW = $clog2(SIG_DIGITS + 1);
	localparam int EW = COUNT_BITS + 4;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;
	localparam logic [HW-1:0] HELD_FULL = HW'(SIG_DIGITS);

	dls_pkg::scan_state_t state_q, state_d;
	logic [dls_pkg::SIG_W-1:0] mant_q, mant_d;
	logic [HW-1:0]             held_q, held_d;
	logic [COUNT_BITS-1:0]     frac_q, frac_d;
	logic [COUNT_BITS-1:0]     drop_q, drop_d;
	logic [COUNT_BITS-1:0]     expm_q, expm_d;
	logic                      neg_q, neg_d;
	logic                      lost_q, lost_d;
	logic [dls_pkg::SFX_W-1:0] sfx_q, sfx_d;

	logic                      dig, ex;
	logic [3:0]                val;
	logic [dls_pkg::SFX_W-1:0] sk;
	logic                      do_int, do_frac, do_exp, set_neg, set_sfx;
	logic [dls_pkg::SIG_W-1:0] mant_x10;
	logic [EW-1:0]             exp_ext, exp_new;
	logic [dls_pkg::EXP_W-1:0] exp_mag, exp_signed, exp_total;
	logic                      ok;

	// Character classes.
	always_comb begin
		dig = (char_code >= dls_pkg::CH_0) && (char_code <= dls_pkg::CH_9);
		val = dig ? 4'(char_code - dls_pkg::CH_0) : 4'd0;
		ex  = (char_code == dls_pkg::CH_E_LO) || (char_code == dls_pkg::CH_E_UP);
		if ((char_code == dls_pkg::CH_F_LO) || (char_code == dls_pkg::CH_F_UP)) begin
			sk = dls_pkg::SFX_F;
		end else if ((char_code == dls_pkg::CH_D_LO) || (char_code == dls_pkg::CH_D_UP)) begin
			sk = dls_pkg::SFX_D;
		end else begin
			sk = dls_pkg::SFX_NONE;
		end
	end

	// Next state.
	always_comb begin
		state_d = dls_pkg::S_REJ;
		case (state_q)
			dls_pkg::S_START: begin
				if (char_code == dls_pkg::CH_POINT) state_d = dls_pkg::S_LEADPT;
				else if (char_code == dls_pkg::CH_0) state_d = dls_pkg::S_ZERO;
				else if (dig) state_d = dls_pkg::S_INT;
			end
			dls_pkg::S_LEADPT: begin
				if (dig) state_d = dls_pkg::S_FRAC;
			end
			dls_pkg::S_FRAC: begin
				if (dig) state_d = dls_pkg::S_FRAC;
				else if (char_code == dls_pkg::CH_US) state_d = dls_pkg::S_FRAC_US;
				else if (ex) state_d = dls_pkg::S_EXP;
				else if (sk != dls_pkg::SFX_NONE) state_d = dls_pkg::S_SUF;
			end
			dls_pkg::S_FRAC_US: begin
				if (char_code == dls_pkg::CH_US) state_d = dls_pkg::S_FRAC_US;
				else if (dig) state_d = dls_pkg::S_FRAC;
			end
			dls_pkg::S_EXP: begin
				if (char_code == dls_pkg::CH_MINUS) state_d = dls_pkg::S_EXP_NEG;
				else if (dig) state_d = dls_pkg::S_EXPD;
			end
			dls_pkg::S_EXP_NEG: begin
				if (dig) state_d = dls_pkg::S_EXPD;
			end
			dls_pkg::S_EXPD: begin
				if (dig) state_d = dls_pkg::S_EXPD;
				else if (char_code == dls_pkg::CH_US) state_d = dls_pkg::S_EXP_US;
				else if (sk != dls_pkg::SFX_NONE) state_d = dls_pkg::S_SUF;
			end
			dls_pkg::S_EXP_US: begin
				if (char_code == dls_pkg::CH_US) state_d = dls_pkg::S_EXP_US;
				else if (dig) state_d = dls_pkg::S_EXPD;
			end
			dls_pkg::S_INT: begin
				if (dig) state_d = dls_pkg::S_INT;
				else if (char_code == dls_pkg::CH_POINT) state_d = dls_pkg::S_POINT;
				else if (char_code == dls_pkg::CH_US) state_d = dls_pkg::S_INT_US;
				else if (ex) state_d = dls_pkg::S_EXP;
				else if (sk != dls_pkg::SFX_NONE) state_d = dls_pkg::S_SUF;
			end
			dls_pkg::S_INT_US: begin
				if (char_code == dls_pkg::CH_US) state_d = dls_pkg::S_INT_US;
				else if (dig) state_d = dls_pkg::S_INT;
			end
			dls_pkg::S_POINT: begin
				if (dig) state_d = dls_pkg::S_FRAC;
				else if (ex) state_d = dls_pkg::S_EXP;
				else if (sk != dls_pkg::SFX_NONE) state_d = dls_pkg::S_SUF;
			end
			dls_pkg::S_ZERO: begin
				if (char_code == dls_pkg::CH_POINT) state_d = dls_pkg::S_POINT;
			end
			default: state_d = dls_pkg::S_REJ;
		endcase
	end

	// Datapath actions decoded from the current state and character.
	always_comb begin
		do_int  = 1'b0;
		do_frac = 1'b0;
		do_exp  = 1'b0;
		set_neg = 1'b0;
		set_sfx = 1'b0;
		case (state_q)
			dls_pkg::S_START:   do_int = dig && (char_code != dls_pkg::CH_0);
			dls_pkg::S_LEADPT:  do_frac = dig;
			dls_pkg::S_FRAC: begin
				do_frac = dig;
				set_sfx = sk != dls_pkg::SFX_NONE;
			end
			dls_pkg::S_FRAC_US: do_frac = dig;
			dls_pkg::S_EXP: begin
				set_neg = char_code == dls_pkg::CH_MINUS;
				do_exp  = dig;
			end
			dls_pkg::S_EXP_NEG: do_exp = dig;
			dls_pkg::S_EXPD: begin
				do_exp  = dig;
				set_sfx = sk != dls_pkg::SFX_NONE;
			end
			dls_pkg::S_EXP_US:  do_exp = dig;
			dls_pkg::S_INT: begin
				do_int  = dig;
				set_sfx = sk != dls_pkg::SFX_NONE;
			end
			dls_pkg::S_INT_US:  do_int = dig;
			dls_pkg::S_POINT: begin
				do_frac = dig;
				set_sfx = sk != dls_pkg::SFX_NONE;
			end
			default: begin
				do_int = 1'b0;
			end
		endcase
	end

	// Accumulator updates.
	always_comb begin
		mant_x10 = (mant_q << 3) + (mant_q << 1) + dls_pkg::SIG_W'(val);
		exp_ext  = EW'(expm_q);
		exp_new  = (exp_ext << 3) + (exp_ext << 1) + EW'(val);

		mant_d = mant_q;
		held_d = held_q;
		frac_d = frac_q;
		drop_d = drop_q;
		expm_d = expm_q;
		neg_d  = neg_q | set_neg;
		lost_d = lost_q;
		sfx_d  = set_sfx ? sk : sfx_q;

		if (do_int) begin
			if (held_q >= HELD_FULL) begin
				lost_d = 1'b1;
				if (drop_q != CMAX) drop_d = drop_q + COUNT_BITS'(1);
			end else begin
				mant_d = mant_x10;
				if (mant_x10 != '0) held_d = held_q + HW'(1);
			end
		end

		if (do_frac) begin
			if ((held_q >= HELD_FULL) || (frac_q == CMAX)) begin
				lost_d = 1'b1;
			end else begin
				frac_d = frac_q + COUNT_BITS'(1);
				if ((mant_q != '0) || (val != 4'd0)) begin
					mant_d = mant_x10;
					held_d = held_q + HW'(1);
				end
			end
		end

		if (do_exp) begin
			if (exp_new > EW'(CMAX)) begin
				expm_d = CMAX;
				lost_d = 1'b1;
			end else begin
				expm_d = exp_new[COUNT_BITS-1:0];
			end
		end
	end

	// Result as seen after this character.
	always_comb begin
		ok = (state_d == dls_pkg::S_FRAC) || (state_d == dls_pkg::S_POINT) ||
			(state_d == dls_pkg::S_EXPD) || (state_d == dls_pkg::S_SUF);
		exp_mag    = dls_pkg::EXP_W'(expm_d);
		exp_signed = neg_d ? (~exp_mag + dls_pkg::EXP_W'(1)) : exp_mag;
		exp_total  = exp_signed - dls_pkg::EXP_W'(frac_d) + dls_pkg::EXP_W'(drop_d);

		result.accepted         = ok;
		result.significand      = ok ? mant_d : '0;
		result.decimal_exponent = ok ? exp_total : '0;
		result.suffix_kind      = ok ? sfx_d : dls_pkg::SFX_NONE;
		result.inexact          = ok & lost_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dls_pkg::S_START;
			mant_q  <= '0;
			held_q  <= '0;
			frac_q  <= '0;
			drop_q  <= '0;
			expm_q  <= '0;
			neg_q   <= 1'b0;
			lost_q  <= 1'b0;
			sfx_q   <= dls_pkg::SFX_NONE;
		end else if (step) begin
			if (is_last) begin
				state_q <= dls_pkg::S_START;
				mant_q  <= '0;
				held_q  <= '0;
				frac_q  <= '0;
				drop_q  <= '0;
				expm_q  <= '0;
				neg_q   <= 1'b0;
				lost_q  <= 1'b0;
				sfx_q   <= dls_pkg::SFX_NONE;
			end else begin
				state_q <= state_d;
				mant_q  <= mant_d;
				held_q  <= held_d;
				frac_q  <= frac_d;
				drop_q  <= drop_d;
				expm_q  <= expm_d;
				neg_q   <= neg_d;
				lost_q  <= lost_d;
				sfx_q   <= sfx_d;
			end
		end
	end

endmodule

/* sv/dls_result.sv */
// Output register that holds one finished result until the sink takes it.
module dls_result (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  dls_pkg::result_t              result,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [dls_pkg::ODATA_W-1:0]   m_axis_tdata,
	output logic [dls_pkg::OUSER_W-1:0]   m_axis_tuser
);

	logic             valid_q;
	dls_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {6'd0, res_q.decimal_exponent, res_q.significand};
	assign m_axis_tuser  = {res_q.inexact, res_q.suffix_kind, res_q.accepted};

endmodule

/* sv/decimal_literal_scanner.sv */
// Top level of the decimal literal scanner: input register, scanner and result register.
//
//   Channel  | Direction | tdata (low bit up)              | tuser / tlast
//   ---------+-----------+---------------------------------+-------------------------------
//   s_axis   | in        | char_code[7:0]                  | tlast = is_last
//   m_axis   | out       | significand[63:0],              | tuser = accepted, suffix_kind,
//            |           | decimal_exponent[81:64], zeros  |         inexact
//
// One character is taken per cycle unless a last character waits for the output
// slot. A character sits in the input register, where the scanner updates its
// state and accumulators in a single pass (the widest step is a times-ten
// shift-add on the 64-bit significand). A character marked last writes its
// result into the output register and returns the scanner to its start state.
// Reset (arst_n low) clears the stages and the scanner at once; no pass is needed.
// While a result waits, characters that are not last keep flowing; only a
// last character waits in the input register until the output slot frees.
module decimal_literal_scanner #(
	parameter int SIG_DIGITS = dls_pkg::SIG_DIGITS_DEF,
	parameter int COUNT_BITS = dls_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input characters.
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [dls_pkg::CHAR_W-1:0]    s_axis_tdata,  // [7:0] char_code
	input  logic                          s_axis_tlast,  // is_last
	// Scan results.
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [dls_pkg::ODATA_W-1:0]   m_axis_tdata,  // [63:0] significand,
	                                                     // [81:64] decimal_exponent,
	                                                     // [87:82] zero
	output logic [dls_pkg::OUSER_W-1:0]   m_axis_tuser   // [0] accepted, [2:1] suffix_kind,
	                                                     // [3] inexact
);

	// Input register stage.
	logic                       valid_s1;
	logic [dls_pkg::CHAR_W-1:0] char_s1;
	logic                       last_s1;

	logic             out_free;
	logic             advance;
	logic             s_take;
	dls_pkg::result_t scan_res;

	// The character in the input register moves on unless it would produce
	// a result while the previous one is still waiting at the output.
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign advance       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_take        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_take) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	dls_scan #(
		.SIG_DIGITS(SIG_DIGITS),
		.COUNT_BITS(COUNT_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_code (char_s1),
		.is_last   (last_s1),
		.result    (scan_res)
	);

	dls_result u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && last_s1),
		.result        (scan_res),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the decimal literal scanner: stream driver, monitor and scanner predictor.
`timescale 1ns / 100ps

module tb_top;
	import dls_pkg::*;

	localparam int SIG_DIGITS = SIG_DIGITS_DEF;
	localparam int COUNT_MAX  = (1 << COUNT_BITS_DEF) - 1;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_AT    = 40;
	localparam int HOLD_LEN   = 600;
	localparam int RAND_CHARS = 1000;

	localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_Q    = 8'h71;

	typedef struct {
		logic [CHAR_W-1:0] code;
		bit                last;
		bit                drain;
		bit                burst;
	} char_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [CHAR_W-1:0]    s_axis_tdata = '0;
	logic                 s_axis_tlast = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [ODATA_W-1:0]   m_axis_tdata;
	logic [OUSER_W-1:0]   m_axis_tuser;

	char_item_t        char_queue[$];
	logic [CHAR_W-1:0] lit[$];
	result_t           scan_results[$];

	// Predictor copy of the scanner state.
	scan_state_t sc_state = S_START;
	logic [63:0] sc_mant = '0;
	int          sc_held = 0;
	int          sc_frac = 0;
	int          sc_drop = 0;
	int          sc_exp = 0;
	bit          sc_neg = 1'b0;
	bit          sc_lossy = 1'b0;
	logic [1:0]  sc_sfx = SFX_NONE;

	int chars_taken = 0;
	int chars_seen = 0;
	int res_taken = 0;
	int res_seen = 0;
	int char_gap = 0;
	int rcv_wait = 0;
	bit snd_fast = 1'b0;
	bit rcv_fast = 1'b0;
	int idle_cycles = 0;
	int mismatches = 0;
	int literals_done = 0;
	int literals_ok = 0;
	int inexact_seen = 0;

	decimal_literal_scanner i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void add_int_digit(input logic [3:0] v);
		if (sc_held >= SIG_DIGITS) begin
			sc_lossy = 1'b1;
			if (sc_drop < COUNT_MAX)
				sc_drop++;
		end else begin
			sc_mant = sc_mant * 64'd10 + 64'(v);
			if (sc_mant != 0)
				sc_held++;
		end
	endfunction

	function automatic void add_frac_digit(input logic [3:0] v);
		if (sc_held >= SIG_DIGITS || sc_frac >= COUNT_MAX) begin
			sc_lossy = 1'b1;
		end else begin
			sc_frac++;
			// Zeros ahead of the first significant digit only move the exponent.
			if (sc_mant != 0 || v != 0) begin
				sc_mant = sc_mant * 64'd10 + 64'(v);
				sc_held++;
			end
		end
	endfunction

	function automatic void add_exp_digit(input logic [3:0] v);
		int e;
		e = sc_exp * 10 + int'(v);
		if (e > COUNT_MAX) begin
			e = COUNT_MAX;
			sc_lossy = 1'b1;
		end
		sc_exp = e;
	endfunction

	function automatic scan_state_t next_scan_state(input logic [CHAR_W-1:0] c);
		bit         dig;
		bit         ex;
		logic [3:0] v;
		logic [1:0] sk;
		dig = (c >= CH_0) && (c <= CH_9);
		v = dig ? 4'(c - CH_0) : 4'd0;
		ex = (c == CH_E_LO) || (c == CH_E_UP);
		sk = (c == CH_F_LO || c == CH_F_UP) ? SFX_F :
		     (c == CH_D_LO || c == CH_D_UP) ? SFX_D : SFX_NONE;
		case (sc_state)
		S_START: begin
			if (c == CH_POINT) return S_LEADPT;
			if (c == CH_0) return S_ZERO;
			if (dig) begin add_int_digit(v); return S_INT; end
			return S_REJ;
		end
		S_LEADPT: begin
			if (dig) begin add_frac_digit(v); return S_FRAC; end
			return S_REJ;
		end
		S_FRAC: begin
			if (dig) begin add_frac_digit(v); return S_FRAC; end
			if (c == CH_US) return S_FRAC_US;
			if (ex) return S_EXP;
			if (sk != SFX_NONE) begin sc_sfx = sk; return S_SUF; end
			return S_REJ;
		end
		S_FRAC_US: begin
			if (c == CH_US) return S_FRAC_US;
			if (dig) begin add_frac_digit(v); return S_FRAC; end
			return S_REJ;
		end
		S_EXP: begin
			if (c == CH_MINUS) begin sc_neg = 1'b1; return S_EXP_NEG; end
			if (dig) begin add_exp_digit(v); return S_EXPD; end
			return S_REJ;
		end
		S_EXP_NEG: begin
			if (dig) begin add_exp_digit(v); return S_EXPD; end
			return S_REJ;
		end
		S_EXPD: begin
			if (dig) begin add_exp_digit(v); return S_EXPD; end
			if (c == CH_US) return S_EXP_US;
			if (sk != SFX_NONE) begin sc_sfx = sk; return S_SUF; end
			return S_REJ;
		end
		S_EXP_US: begin
			if (c == CH_US) return S_EXP_US;
			if (dig) begin add_exp_digit(v); return S_EXPD; end
			return S_REJ;
		end
		S_INT: begin
			if (dig) begin add_int_digit(v); return S_INT; end
			if (c == CH_POINT) return S_POINT;
			if (c == CH_US) return S_INT_US;
			if (ex) return S_EXP;
			if (sk != SFX_NONE) begin sc_sfx = sk; return S_SUF; end
			return S_REJ;
		end
		S_INT_US: begin
			if (c == CH_US) return S_INT_US;
			if (dig) begin add_int_digit(v); return S_INT; end
			return S_REJ;
		end
		S_POINT: begin
			if (dig) begin add_frac_digit(v); return S_FRAC; end
			if (ex) return S_EXP;
			if (sk != SFX_NONE) begin sc_sfx = sk; return S_SUF; end
			return S_REJ;
		end
		S_ZERO: begin
			if (c == CH_POINT) return S_POINT;
			return S_REJ;
		end
		default: return S_REJ;
		endcase
	endfunction

	// Advances the predictor by one character; a last character queues its result.
	function automatic void scan_char(input logic [CHAR_W-1:0] c, input logic last);
		result_t r;
		int      e;
		sc_state = next_scan_state(c);
		if (last) begin
			r = '0;
			if (sc_state == S_FRAC || sc_state == S_POINT || sc_state == S_EXPD ||
			    sc_state == S_SUF) begin
				e = (sc_neg ? -sc_exp : sc_exp) - sc_frac + sc_drop;
				r.accepted = 1'b1;
				r.significand = sc_mant;
				r.decimal_exponent = e[EXP_W-1:0];
				r.suffix_kind = sc_sfx;
				r.inexact = sc_lossy;
			end
			scan_results.push_back(r);
			sc_state = S_START;
			sc_mant = '0;
			sc_held = 0;
			sc_frac = 0;
			sc_drop = 0;
			sc_exp = 0;
			sc_neg = 1'b0;
			sc_lossy = 1'b0;
			sc_sfx = SFX_NONE;
		end
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			lit.push_back(s[i]);
	endfunction

	function automatic void add_digits(input int n, input bit first_nonzero, input bit with_us);
		for (int i = 0; i < n; i++) begin
			if (with_us && i > 0 && $urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 3)) lit.push_back(CH_US);
			if (i == 0 && first_nonzero)
				lit.push_back(CH_0 + 8'($urandom_range(1, 9)));
			else
				lit.push_back(CH_0 + 8'($urandom_range(0, 9)));
		end
	endfunction

	// Mostly short digit runs, now and then long enough to fill the significand.
	function automatic int pick_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 6);
	endfunction

	function automatic void add_lead_zeros();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 5)) lit.push_back(CH_0);
	endfunction

	function automatic void add_wellformed();
		bit has_pt;
		bit has_exp;
		bit has_sfx;
		has_exp = ($urandom_range(0, 2) == 0);
		has_sfx = 1'($urandom_range(0, 1));
		has_pt = 1'b1;
		case ($urandom_range(0, 5))
		0: begin
			lit.push_back(CH_POINT);
			add_lead_zeros();
			add_digits(pick_len(), 1'b0, 1'b1);
		end
		1: begin
			lit.push_back(CH_0);
			lit.push_back(CH_POINT);
			add_lead_zeros();
			if ($urandom_range(0, 1))
				add_digits(pick_len(), 1'b0, 1'b1);
		end
		default: begin
			add_digits(pick_len(), 1'b1, 1'b1);
			has_pt = ($urandom_range(0, 2) != 0);
			if (has_pt) begin
				lit.push_back(CH_POINT);
				if ($urandom_range(0, 3) != 0)
					add_digits(pick_len(), 1'b0, 1'b1);
			end
		end
		endcase
		// A bare integer is rejected; keep it rare.
		if (!has_pt && !has_exp && $urandom_range(0, 3) != 0)
			has_sfx = 1'b1;
		if (has_exp) begin
			lit.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
			if ($urandom_range(0, 1))
				lit.push_back(CH_MINUS);
			add_digits($urandom_range(1, 6), 1'b0, 1'b1);
		end
		if (has_sfx) begin
			case ($urandom_range(0, 3))
			0: lit.push_back(CH_F_LO);
			1: lit.push_back(CH_F_UP);
			2: lit.push_back(CH_D_LO);
			default: lit.push_back(CH_D_UP);
			endcase
		end
	endfunction

	function automatic logic [CHAR_W-1:0] odd_char();
		case ($urandom_range(0, 9))
		0: return CH_US;
		1: return CH_POINT;
		2: return CH_MINUS;
		3: return CH_PLUS;
		4: return CH_Q;
		5: return CH_E_UP;
		6: return CH_D_LO;
		7: return CH_0 + 8'($urandom_range(0, 9));
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Breaks a literal by replacing, inserting or deleting one character.
	function automatic void break_literal();
		int pos;
		pos = $urandom_range(0, lit.size() - 1);
		case ($urandom_range(0, 3))
		0: lit.push_back(odd_char());
		1: lit.insert(pos, odd_char());
		2: if (lit.size() > 1) lit.delete(pos); else lit[pos] = odd_char();
		default: lit[pos] = odd_char();
		endcase
	endfunction

	function automatic void commit_literal(input bit drain, input bit burst);
		char_item_t it;
		for (int i = 0; i < lit.size(); i++) begin
			it.code = lit[i];
			it.last = (i == lit.size() - 1);
			it.drain = drain && (i == 0);
			it.burst = burst;
			char_queue.push_back(it);
		end
		lit.delete();
	endfunction

	function automatic int next_gap();
		if ($urandom_range(0, 39) == 0)
			snd_fast = !snd_fast;
		if (char_queue.size() != 0 && char_queue[0].burst)
			return 0;
		return snd_fast ? 0 : $urandom_range(0, 13);
	endfunction

	// ---------------------------------------------------------------- driver

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || chars_taken != chars_seen) begin
				if (chars_taken != chars_seen) begin
					chars_seen = chars_taken;
					char_gap = next_gap();
				end
				if (char_gap != 0) begin
					char_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (char_queue.size() != 0 &&
				             !(char_queue[0].drain && scan_results.size() != 0)) begin
					s_axis_tdata <= char_queue[0].code;
					s_axis_tlast <= char_queue[0].last;
					s_axis_tvalid <= 1'b1;
					void'(char_queue.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result side back-pressure; one long hold-off lets the scanner fill up.
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken != res_seen) begin
				res_seen = res_taken;
				if ($urandom_range(0, 39) == 0)
					rcv_fast = !rcv_fast;
				if (res_taken == HOLD_AT)
					rcv_wait = HOLD_LEN;
				else
					rcv_wait = rcv_fast ? 0 : $urandom_range(0, 13);
			end
			if (rcv_wait != 0) begin
				rcv_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic check_field(input string name, input logic [63:0] want,
	                           input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (s_axis_tvalid && s_axis_tready) begin
			chars_taken++;
			scan_char(s_axis_tdata, s_axis_tlast);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			res_taken++;
			if (scan_results.size() == 0) begin
				$error("result with no literal pending: tdata %0h, tuser %0h",
				       m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = scan_results.pop_front();
				check_field("accepted", 64'(want.accepted), 64'(m_axis_tuser[0]));
				check_field("significand", want.significand, m_axis_tdata[63:0]);
				check_field("decimal_exponent", 64'(want.decimal_exponent[EXP_W-1:0]),
				            64'(m_axis_tdata[81:64]));
				check_field("suffix_kind", 64'(want.suffix_kind), 64'(m_axis_tuser[2:1]));
				check_field("inexact", 64'(want.inexact), 64'(m_axis_tuser[3]));
				check_field("tdata_pad", '0, 64'(m_axis_tdata[ODATA_W-1:82]));
				literals_done++;
				if (want.accepted) literals_ok++;
				if (want.inexact) inexact_seen++;
			end
		end
	end

	// A stalled handshake on both sides for too long ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("timeout after %0d idle cycles", idle_cycles);
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int rand_chars;
		int lit_cnt;
		int kind;

		// Directed literals: accepted forms, a lower-case d and an upper-case F
		// suffix, the rejected bare integer, plus sign, trailing exponent underscore,
		// an invalid letter and the two extreme codes.
		add_text("0.");                commit_literal(1'b0, 1'b0);
		add_text(".5d");               commit_literal(1'b0, 1'b0);
		add_text("1_2.0_3E-0_7F");     commit_literal(1'b0, 1'b0);
		add_text("12");                commit_literal(1'b0, 1'b0);
		add_text("1e+2");              commit_literal(1'b0, 1'b0);
		add_text("1e5_");              commit_literal(1'b0, 1'b0);
		add_text("q");                 commit_literal(1'b0, 1'b0);
		lit.push_back(8'h00);          commit_literal(1'b0, 1'b0);
		lit.push_back(8'hFF);          commit_literal(1'b0, 1'b0);

		// An over-long integer part drops digits, and the fraction digit after
		// it is dropped too. It goes out back to back once every earlier
		// result has come out.
		add_digits(24, 1'b1, 1'b0);
		add_text(".5e-12d");
		commit_literal(1'b1, 1'b1);

		// The exponent magnitude runs into saturation.
		add_text("1.5e-987654");
		commit_literal(1'b0, 1'b1);

		// Random part: mostly well-formed literals, some broken, some noise.
		rand_chars = 0;
		lit_cnt = 0;
		while (rand_chars < RAND_CHARS) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				add_wellformed();
			end else if (kind < 9) begin
				add_wellformed();
				break_literal();
			end else begin
				repeat ($urandom_range(1, 6)) lit.push_back(8'($urandom_range(0, 255)));
			end
			rand_chars += lit.size();
			commit_literal(lit_cnt % 50 == 0, 1'b0);
			lit_cnt++;
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (char_queue.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (scan_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("scanned %0d characters in %0d literals: %0d accepted, %0d inexact",
		         chars_taken, literals_done, literals_ok, inexact_seen);
		$display("included saturated counts, a %0d-cycle result hold-off and drained pauses",
		         HOLD_LEN);
		if (mismatches == 0 && scan_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
